/* design/utc_pkg.sv */
// shared types, constants and month-length helper for the utc to local time converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package utc_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int OFFSET_W = 4;
    localparam int QUART_W  = YEAR_W - 2;
    localparam int Q25_W    = 6;
    localparam int DIV25_PROD_W = 21;
    localparam int DATA_W   = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OFFSET_W;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_HOURS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EAST_OF_UTC  = 1'd1;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd8;
    localparam logic                EAST_RESET   = 1'b1;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 4'd12;

    localparam logic [HOUR_W:0]  HOURS_PER_DAY = 6'd24;
    localparam logic [MONTH_W-1:0] M_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] M_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_31 = 5'd31;
    localparam logic [DAY_W-1:0]   DAY_30 = 5'd30;
    localparam logic [DAY_W-1:0]   DAY_29 = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_28 = 5'd28;
    localparam logic [DAY_W-1:0]   DAY_NONE = 5'd0;

    // floor(k / 25) for k < 1024 as (k * 1311) >> 15
    localparam logic [DIV25_PROD_W-1:0] DIV25_MUL = 21'd1311;
    localparam int DIV25_SHIFT = 15;
    localparam logic [QUART_W-1:0] CENTURY_QUARTS = 10'd25;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_time;

    typedef struct packed {
        t_time             tm;
        logic              conv;
        logic              carry;
        logic              borrow;
        logic [Q25_W-1:0]  q25;
    } t_s1;

    typedef struct packed {
        t_time             tm;
        logic              conv;
        logic              carry;
        logic              borrow;
        logic [DAY_W-1:0]  last_cur;
        logic [DAY_W-1:0]  last_prev;
    } t_s2;

    typedef struct packed {
        t_time tm;
        logic  conv;
    } t_s3;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] d;
        d = DAY_NONE;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = DAY_30;
            4'd2:                                        d = leap ? DAY_29 : DAY_28;
            default:                                     d = DAY_NONE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* design/utc_hour_stage.sv */
// stage 1: hour shift by zone offset, day carry or borrow flags, year / 100 quotient
// depends on utc_pkg
`timescale 1ns / 1ps
`default_nettype none

module utc_hour_stage (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  utc_pkg::t_time                     i_tm,
    input  wire [utc_pkg::OFFSET_W-1:0]        i_offset,
    input  wire                                i_east,
    output logic                               o_valid,
    input  wire                                i_ready,
    output utc_pkg::t_s1                       o_data
);

    logic                 r_v;
    utc_pkg::t_s1         r_d;
    utc_pkg::t_s1         n_d;
    logic                 w_load;
    logic [utc_pkg::HOUR_W:0] w_sum;
    logic [utc_pkg::DIV25_PROD_W-1:0] w_prod;

    assign o_ready = !r_v || i_ready;
    assign w_load  = o_ready && i_valid;
    assign o_valid = r_v;
    assign o_data  = r_d;

    assign w_prod = utc_pkg::DIV25_PROD_W'(i_tm.year[utc_pkg::YEAR_W-1:2])
                    * utc_pkg::DIV25_MUL;

    always_comb begin
        n_d        = '0;
        n_d.tm     = i_tm;
        n_d.q25    = w_prod[utc_pkg::DIV25_SHIFT +: utc_pkg::Q25_W];
        w_sum      = {1'b0, i_tm.hour} + {2'b00, i_offset};
        if (i_offset != '0 && i_offset <= utc_pkg::OFFSET_MAX) begin
            n_d.conv = 1'b1;
            if (i_east) begin
                if (w_sum < utc_pkg::HOURS_PER_DAY) begin
                    n_d.tm.hour = w_sum[utc_pkg::HOUR_W-1:0];
                end else begin
                    n_d.tm.hour  = utc_pkg::HOUR_W'(w_sum - utc_pkg::HOURS_PER_DAY);
                    n_d.carry    = 1'b1;
                end
            end else begin
                if (i_tm.hour >= {1'b0, i_offset}) begin
                    n_d.tm.hour = i_tm.hour - {1'b0, i_offset};
                end else begin
                    n_d.tm.hour = utc_pkg::HOUR_W'(w_sum - {2'b00, i_offset}
                                  - {2'b00, i_offset} + utc_pkg::HOURS_PER_DAY);
                    n_d.borrow  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_d <= n_d;
        end
    end

endmodule

`default_nettype wire

/* design/utc_mlen_stage.sv */
// stage 2: leap year decision and lengths of the current and previous month
// depends on utc_pkg
`timescale 1ns / 1ps
`default_nettype none

module utc_mlen_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  utc_pkg::t_s1   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output utc_pkg::t_s2   o_data
);

    logic                 r_v;
    utc_pkg::t_s2         r_d;
    utc_pkg::t_s2         n_d;
    logic                 w_load;
    logic                 w_century;
    logic                 w_leap;
    logic [utc_pkg::MONTH_W-1:0] w_prev_m;
    logic [utc_pkg::QUART_W-1:0] w_back;

    assign o_ready = !r_v || i_ready;
    assign w_load  = o_ready && i_valid;
    assign o_valid = r_v;
    assign o_data  = r_d;

    assign w_back    = utc_pkg::QUART_W'(i_data.q25) * utc_pkg::CENTURY_QUARTS;
    assign w_century = (w_back == i_data.tm.year[utc_pkg::YEAR_W-1:2]);
    assign w_leap    = (i_data.tm.year[1:0] == 2'b00) &&
                       (!w_century || i_data.q25[1:0] == 2'b00);
    assign w_prev_m  = (i_data.tm.month == utc_pkg::M_JAN) ? utc_pkg::M_DEC
                                                            : i_data.tm.month - 4'd1;

    always_comb begin
        n_d.tm        = i_data.tm;
        n_d.conv      = i_data.conv;
        n_d.carry     = i_data.carry;
        n_d.borrow    = i_data.borrow;
        n_d.last_cur  = utc_pkg::month_len(i_data.tm.month, w_leap);
        n_d.last_prev = utc_pkg::month_len(w_prev_m, w_leap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_d <= n_d;
        end
    end

endmodule

`default_nettype wire

/* design/utc_date_stage.sv */
// stage 3: day, month and year carry or borrow, output register
// depends on utc_pkg
`timescale 1ns / 1ps
`default_nettype none

module utc_date_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  utc_pkg::t_s2   i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output utc_pkg::t_s3   o_data
);

    logic           r_v;
    utc_pkg::t_s3   r_d;
    utc_pkg::t_s3   n_d;
    logic           w_load;
    logic           w_month_ok;

    assign o_ready = !r_v || i_ready;
    assign w_load  = o_ready && i_valid;
    assign o_valid = r_v;
    assign o_data  = r_d;

    assign w_month_ok = (i_data.tm.month >= utc_pkg::M_JAN) &&
                        (i_data.tm.month <= utc_pkg::M_DEC);

    always_comb begin
        n_d.tm   = i_data.tm;
        n_d.conv = i_data.conv;
        if (i_data.carry && w_month_ok) begin
            if (i_data.tm.day < i_data.last_cur) begin
                n_d.tm.day = i_data.tm.day + 5'd1;
            end else begin
                n_d.tm.day = utc_pkg::DAY_FIRST;
                if (i_data.tm.month == utc_pkg::M_DEC) begin
                    n_d.tm.month = utc_pkg::M_JAN;
                    n_d.tm.year  = i_data.tm.year + 12'd1;
                end else begin
                    n_d.tm.month = i_data.tm.month + 4'd1;
                end
            end
        end else if (i_data.borrow && w_month_ok) begin
            if (i_data.tm.day > utc_pkg::DAY_FIRST) begin
                n_d.tm.day = i_data.tm.day - 5'd1;
            end else if (i_data.tm.month == utc_pkg::M_JAN) begin
                n_d.tm.month = utc_pkg::M_DEC;
                n_d.tm.day   = utc_pkg::DAY_31;
                n_d.tm.year  = i_data.tm.year - 12'd1;
            end else begin
                n_d.tm.month = i_data.tm.month - 4'd1;
                n_d.tm.day   = i_data.last_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_d <= n_d;
        end
    end

endmodule

`default_nettype wire

/* design/utc_to_local_time_convert.sv */
// utc to local time converter, top level: config registers and three-stage pipeline
// depends on utc_pkg, utc_hour_stage, utc_mlen_stage, utc_date_stage
// pipeline: each accepted word passes the hour, month-length and date stage registers in turn
// throughput: one word per cycle; each stage holds its word while the next one stalls
// reset: synchronous active low, clears all stage valids, offset to 8 hours east
`timescale 1ns / 1ps
`default_nettype none

module utc_to_local_time_convert (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [utc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire [utc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // utc_year, utc_month, utc_day, utc_hour, utc_minute, utc_second, zero pad
    input  wire [utc_pkg::DATA_W-1:0]            s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // local_year, local_month, local_day, local_hour, local_minute, local_second, zero pad
    output logic [utc_pkg::DATA_W-1:0]           m_axis_tdata,
    // converted
    output logic                                 m_axis_tuser
);

    logic [utc_pkg::OFFSET_W-1:0] r_offset;
    logic                         r_east;
    utc_pkg::t_time               w_in_tm;
    utc_pkg::t_s1                 w_s1;
    utc_pkg::t_s2                 w_s2;
    utc_pkg::t_s3                 w_s3;
    logic                         w_v1;
    logic                         w_v2;
    logic                         w_rdy2;
    logic                         w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= utc_pkg::OFFSET_RESET;
            r_east   <= utc_pkg::EAST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                utc_pkg::REG_OFFSET_HOURS: r_offset <= i_cfg_wdata;
                utc_pkg::REG_EAST_OF_UTC:  r_east   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_in_tm.year   = s_axis_tdata[11:0];
    assign w_in_tm.month  = s_axis_tdata[15:12];
    assign w_in_tm.day    = s_axis_tdata[20:16];
    assign w_in_tm.hour   = s_axis_tdata[25:21];
    assign w_in_tm.minute = s_axis_tdata[31:26];
    assign w_in_tm.second = s_axis_tdata[37:32];

    utc_hour_stage u_hour (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_tm     (w_in_tm),
        .i_offset (r_offset),
        .i_east   (r_east),
        .o_valid  (w_v1),
        .i_ready  (w_rdy2),
        .o_data   (w_s1)
    );

    utc_mlen_stage u_mlen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v1),
        .o_ready  (w_rdy2),
        .i_data   (w_s1),
        .o_valid  (w_v2),
        .i_ready  (w_rdy3),
        .o_data   (w_s2)
    );

    utc_date_stage u_date (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v2),
        .o_ready  (w_rdy3),
        .i_data   (w_s2),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (w_s3)
    );

    assign m_axis_tdata = {2'b00, w_s3.tm.second, w_s3.tm.minute, w_s3.tm.hour,
                           w_s3.tm.day, w_s3.tm.month, w_s3.tm.year};
    assign m_axis_tuser = w_s3.conv;

endmodule

`default_nettype wire
